### hdl/tctl_pkg.sv
// tctl_pkg: shared types and constants for the timed cue table locator
// transaction payload structs, opcodes, controller states, command and status groups
// no dependencies
package tctl_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;
	localparam int TIME_W              = 32;
	localparam int OUT_IDX_W           = 8;
	localparam int OUT_CNT_W           = 9;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_TIME   = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [TIME_W-1:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] current_index;
		logic                 index_valid;
		logic                 index_changed;
		logic [OUT_CNT_W-1:0] entry_count;
		logic                 insert_dropped;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic srch_init;
		logic srch_rd;
		logic srch_step;
		logic shift_init;
		logic shift_rd;
		logic shift_wr;
		logic put;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       full;
		logic       empty;
		logic       srch_busy;
		logic       shift_busy;
		logic       out_free;
	} dp_stat_t;

endpackage

### hdl/tctl_ctrl.sv
// tctl_ctrl: sequencing state machine of the cue table locator
// drives datapath commands from its status; depends on tctl_pkg
module tctl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  tctl_pkg::dp_stat_t stat,
	output tctl_pkg::dp_cmd_t  cmd
);
	import tctl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if ((stat.opcode == OP_INSERT && !stat.full) ||
				    (stat.opcode == OP_TIME && !stat.empty)) begin
					cmd.srch_init = 1'b1;
					state_d       = ST_SRCH_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SRCH_RD: begin
				if (stat.srch_busy) begin
					cmd.srch_rd = 1'b1;
					state_d     = ST_SRCH_CMP;
				end else if (stat.opcode == OP_INSERT) begin
					cmd.shift_init = 1'b1;
					state_d        = ST_SHIFT_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SRCH_CMP: begin
				cmd.srch_step = 1'b1;
				state_d       = ST_SRCH_RD;
			end
			ST_SHIFT_RD: begin
				if (stat.shift_busy) begin
					cmd.shift_rd = 1'b1;
					state_d      = ST_SHIFT_WR;
				end else begin
					cmd.put = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_FINISH: begin
				// hold here until the result register can take the transaction
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/tctl_dp.sv
// tctl_dp: datapath of the cue table locator
// cue memory, search bounds, shift pointer, position state and result register; depends on tctl_pkg
module tctl_dp #(
	parameter int TABLE_DEPTH = tctl_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tctl_pkg::in_item_t  item,
	input  tctl_pkg::dp_cmd_t   cmd,
	output tctl_pkg::dp_stat_t  stat,
	output logic                result_valid,
	input  logic                result_ready,
	output tctl_pkg::out_item_t result
);
	import tctl_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [TIME_W-1:0] mem [TABLE_DEPTH];

	logic [1:0]        op_q;
	logic [TIME_W-1:0] time_q;
	logic              drop_q;
	logic [CNT_W-1:0]  lo_q, hi_q, ptr_q;
	logic [TIME_W-1:0] rdata_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  pos_q;
	logic              pos_valid_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [CNT_W-1:0]  mid, ptr_m1;
	logic              full, empty;

	logic [CNT_W-1:0]  cnt_n;
	logic [IDX_W-1:0]  pos_n;
	logic              val_n, chg_n;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign ptr_m1 = ptr_q - 1'b1;
	assign full   = (count_q == CNT_W'(TABLE_DEPTH));
	assign empty  = (count_q == '0);

	assign stat.opcode     = op_q;
	assign stat.full       = full;
	assign stat.empty      = empty;
	assign stat.srch_busy  = (lo_q < hi_q);
	assign stat.shift_busy = (ptr_q > lo_q);
	assign stat.out_free   = !out_valid_q || result_ready;

	// item latch, search bounds and shift pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= item.opcode;
			time_q <= item.time_ms;
			drop_q <= (item.opcode == OP_INSERT) && full;
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.srch_step) begin
			if (rdata_q <= time_q) begin
				lo_q <= mid + 1'b1;
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.shift_init) begin
			ptr_q <= count_q;
		end else if (cmd.shift_wr) begin
			ptr_q <= ptr_m1;
		end
	end

	// cue memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.shift_wr) begin
			mem[ptr_q[IDX_W-1:0]] <= rdata_q;
		end else if (cmd.put) begin
			mem[lo_q[IDX_W-1:0]] <= time_q;
		end
		if (cmd.srch_rd) begin
			rdata_q <= mem[mid[IDX_W-1:0]];
		end else if (cmd.shift_rd) begin
			rdata_q <= mem[ptr_m1[IDX_W-1:0]];
		end
	end

	// effect of the item on count and position at the end of the transaction
	always_comb begin
		cnt_n = count_q;
		pos_n = pos_q;
		val_n = pos_valid_q;
		chg_n = 1'b0;
		case (op_q)
			OP_CLEAR: begin
				chg_n = pos_valid_q;
				cnt_n = '0;
				pos_n = '0;
				val_n = 1'b0;
			end
			OP_TIME: begin
				if (!empty) begin
					// lo holds the number of cues at or before the time
					val_n = (lo_q != '0);
					pos_n = val_n ? IDX_W'(lo_q - 1'b1) : '0;
					chg_n = (val_n != pos_valid_q) || (val_n && pos_n != pos_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			pos_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.put) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.finish) begin
				count_q <= cnt_n;
			end
			if (cmd.finish) begin
				pos_q       <= pos_n;
				pos_valid_q <= val_n;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.current_index  <= val_n ? OUT_IDX_W'(pos_n) : '0;
			out_q.index_valid    <= val_n;
			out_q.index_changed  <= chg_n;
			out_q.entry_count    <= OUT_CNT_W'(cnt_n);
			out_q.insert_dropped <= drop_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### hdl/timed_cue_table_locator.sv
// timed_cue_table_locator: top level of the sorted cue table with last-at-or-before search
// joins tctl_ctrl and tctl_dp; depends on tctl_pkg
//
//   channel   valid          ready          payload
//   item      item_valid     item_ready     item   (tctl_pkg::in_item_t)
//   result    result_valid   result_ready   result (tctl_pkg::out_item_t)
//
// clear, unused opcode, refused insert and time on an empty table: decode, then finish
// time and insert search: each memory probe is a read state then a compare state, at most
//   ceil(log2(count+1)) probes, then a state to leave the search; one read port on the cue memory
//   sets this; an insert then moves each later entry up with a read and a write state, then writes the new entry
// reset is asynchronous: table empty, position none; memory contents are not cleared
// a waiting result does not stop the next item, only its final cycle waits for result_ready
module timed_cue_table_locator #(
	parameter int TABLE_DEPTH = tctl_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tctl_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output tctl_pkg::out_item_t result
);
	import tctl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tctl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	tctl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// an accepted transaction keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous transaction in progress");

	a_none_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.index_valid |-> result.current_index == '0)
		else $error("current index not zero with no current cue");

	a_drop_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.insert_dropped |->
		result.entry_count == OUT_CNT_W'(TABLE_DEPTH) && !result.index_changed)
		else $error("dropped insert with table not full or position changed");

endmodule
